FILE: hdl/ffha_pkg.sv
// shared types and constants for the first-fit heap allocator
// used by the controller, the datapath and the top level
package ffha_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_BYTES = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic clr_step;   // clearing pass, one unit
    logic load;       // latch the item
    logic rd_cur;     // read entry at cursor
    logic adv;        // cursor to next chunk
    logic split;      // write split chunk at cursor
    logic mark_used;  // set used at cursor
    logic free_rd;    // read entry named by free
    logic merge_rd;   // read successor of merge base
    logic merge_wr;   // absorb successor
    logic pred_rd;    // read predecessor entry
    logic pred_set;   // merge base to predecessor
    logic unmark;     // clear used at free chunk
    logic fix_pred;   // write predecessor of chunk after merge
    logic res_ok_a;
    logic res_oom;
    logic res_ok_f;
    logic res_bad;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic walk_end;   // cursor past heap or zero length or step limit
    logic fits;       // cursor chunk free and long enough
    logic split_ok;   // more than two units left after the request
    logic free_ok;    // address checks and used chunk start
    logic merge_ok;   // successor exists and is free
    logic pred_ok;    // predecessor free chunk start
    logic is_zero;    // free chunk at unit zero
    logic after_ok;   // chunk after merge is inside heap
  } sts_t;

endpackage

FILE: hdl/ffha_datapath.sv
// datapath: chunk tables, cursor, address checks and result register
// depends on ffha_pkg for command and status types
module ffha_datapath #(
  parameter int UnitBytes = 16,
  parameter int HeapUnits = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffha_pkg::cmd_t      cmd_i,
  output ffha_pkg::sts_t      sts_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [15:0]         req_i,
  input  logic [31:0]         addr_i,
  output logic [1:0]          status_o,
  output logic [31:0]         grant_o
);
  localparam int UW = $clog2(HeapUnits);
  localparam int LW = UW + 1;
  localparam int SH = $clog2(UnitBytes);

  logic [31:0] base_q;
  logic [16:0] bytes_q;
  logic [LW-1:0] total_q;

  logic start_mem [HeapUnits];
  logic used_mem  [HeapUnits];
  logic [LW-1:0] len_mem  [HeapUnits];
  logic [UW-1:0] pred_mem [HeapUnits];

  logic [LW-1:0] cur_q, mb_q, fi_q, clr_q;
  logic [LW-1:0] steps_q;
  logic [LW-1:0] need_q, len_q, blen_q;
  logic          st_q, us_q;
  logic [UW-1:0] prd_q;
  logic          addr_ok_q;
  logic [1:0]    status_q;
  logic [31:0]   grant_q;

  // heap units from a byte count, saturated
  logic [16:0] units_raw;
  logic [LW-1:0] units_sat;
  logic [16:0] cfg_bytes;
  assign cfg_bytes = (cfg_we_i && cfg_idx_i == ffha_pkg::CFG_BYTES) ? cfg_data_i[16:0]
                                                                     : bytes_q;
  assign units_raw = cfg_bytes >> SH;
  assign units_sat = (units_raw > 17'(HeapUnits)) ? LW'(HeapUnits) : LW'(units_raw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      bytes_q <= 17'd65536;
      total_q <= '0;
      clr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ffha_pkg::CFG_BASE) base_q <= cfg_data_i;
        else bytes_q <= cfg_data_i[16:0];
        total_q <= units_sat;
        clr_q   <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == '0) total_q <= units_sat;
      end
    end
  end

  // request length in units with header; longer than the heap never fits
  logic [17:0] need_w;
  logic [LW-1:0] need_d;
  assign need_w = 18'(({1'b0, req_i} + 17'(UnitBytes - 1)) >> SH) + 18'd1;
  assign need_d = (need_w > 18'(HeapUnits)) ? LW'(HeapUnits + 1) : LW'(need_w);

  // free address checks
  logic [31:0] off;
  logic [31:0] q;
  assign off = addr_i - base_q;
  assign q   = off >> SH;

  logic [LW-1:0] nxt, cur_end, split_n;
  assign cur_end = cur_q + len_q;
  assign split_n = cur_q + need_q;
  assign nxt     = mb_q + blen_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && clr_q < LW'(HeapUnits)) begin
      start_mem[clr_q[UW-1:0]] <= (clr_q == '0);
      used_mem[clr_q[UW-1:0]]  <= 1'b0;
      if (clr_q == '0) len_mem[clr_q[UW-1:0]] <= units_sat;
    end
    if (cmd_i.load) begin
      need_q    <= need_d;
      cur_q     <= '0;
      steps_q   <= '0;
      addr_ok_q <= (off[SH-1:0] == '0) && (q != 0) && (q <= 32'(total_q));
      fi_q      <= LW'(q - 1);
      mb_q      <= LW'(q - 1);
    end
    if (cmd_i.rd_cur) begin
      len_q <= len_mem[cur_q[UW-1:0]];
      us_q  <= used_mem[cur_q[UW-1:0]];
    end
    if (cmd_i.adv) begin
      cur_q   <= cur_end;
      steps_q <= steps_q + 1'b1;
    end
    if (cmd_i.split) begin
      start_mem[split_n[UW-1:0]] <= 1'b1;
      used_mem[split_n[UW-1:0]]  <= 1'b0;
      len_mem[split_n[UW-1:0]]   <= len_q - need_q;
      pred_mem[split_n[UW-1:0]]  <= cur_q[UW-1:0];
      if (cur_end < total_q) pred_mem[cur_end[UW-1:0]] <= split_n[UW-1:0];
      len_mem[cur_q[UW-1:0]] <= need_q;
    end
    if (cmd_i.mark_used) used_mem[cur_q[UW-1:0]] <= 1'b1;
    if (cmd_i.free_rd) begin
      st_q   <= start_mem[fi_q[UW-1:0]];
      us_q   <= used_mem[fi_q[UW-1:0]];
      blen_q <= len_mem[fi_q[UW-1:0]];
      prd_q  <= pred_mem[fi_q[UW-1:0]];
    end
    if (cmd_i.unmark) used_mem[fi_q[UW-1:0]] <= 1'b0;
    if (cmd_i.merge_rd) begin
      if (nxt < total_q) begin
        st_q  <= start_mem[nxt[UW-1:0]];
        us_q  <= used_mem[nxt[UW-1:0]];
        len_q <= len_mem[nxt[UW-1:0]];
      end else begin
        st_q <= 1'b0;
        us_q <= 1'b1;
      end
    end
    if (cmd_i.merge_wr) begin
      len_mem[mb_q[UW-1:0]]  <= blen_q + len_q;
      blen_q                 <= blen_q + len_q;
      start_mem[nxt[UW-1:0]] <= 1'b0;
      len_mem[nxt[UW-1:0]]   <= '0;
    end
    if (cmd_i.fix_pred) pred_mem[nxt[UW-1:0]] <= mb_q[UW-1:0];
    if (cmd_i.pred_rd) begin
      st_q   <= start_mem[prd_q];
      us_q   <= used_mem[prd_q];
      blen_q <= len_mem[prd_q];
    end
    if (cmd_i.pred_set) mb_q <= LW'(prd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ffha_pkg::ST_OK;
      grant_q  <= '0;
    end else if (cmd_i.res_ok_a) begin
      status_q <= ffha_pkg::ST_OK;
      grant_q  <= base_q + (32'(cur_q) + 32'd1) * 32'(UnitBytes);
    end else if (cmd_i.res_oom) begin
      status_q <= ffha_pkg::ST_OOM;
      grant_q  <= '0;
    end else if (cmd_i.res_ok_f) begin
      status_q <= ffha_pkg::ST_OK;
      grant_q  <= '0;
    end else if (cmd_i.res_bad) begin
      status_q <= ffha_pkg::ST_BADFREE;
      grant_q  <= '0;
    end
  end

  // split only when more than two units remain
  logic split_need;
  assign split_need = (len_q - need_q) > LW'(2);

  always_comb begin
    sts_o.clr_done = (clr_q == LW'(HeapUnits));
    sts_o.walk_end = (cur_q >= total_q) || (len_q == '0) || (steps_q >= LW'(HeapUnits));
    sts_o.fits     = !us_q && (len_q >= need_q);
    sts_o.split_ok = split_need;
    sts_o.free_ok  = addr_ok_q && st_q && us_q;
    sts_o.merge_ok = st_q && !us_q;
    sts_o.pred_ok  = st_q && !us_q;
    sts_o.is_zero  = (fi_q == '0);
    sts_o.after_ok = nxt < total_q;
  end

  assign status_o = status_q;
  assign grant_o  = grant_q;
endmodule

FILE: hdl/ffha_ctrl.sv
// controller: sequences clearing pass, allocation walk and free merges
// depends on ffha_pkg for command and status types
module ffha_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           in_fire_i,
  output logic           in_ready_o,
  input  logic           out_free_i,
  output logic           out_load_o,
  input  logic           op_i,
  input  ffha_pkg::sts_t sts_i,
  output ffha_pkg::cmd_t cmd_o
);
  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_RD    = 12'b000000000100,
    S_CHK   = 12'b000000001000,
    S_FRD   = 12'b000000010000,
    S_FCHK  = 12'b000000100000,
    S_MRD   = 12'b000001000000,
    S_MCHK  = 12'b000010000000,
    S_FIX   = 12'b000100000000,
    S_PRD   = 12'b001000000000,
    S_PCHK  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic   pstage_q, pstage_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      pstage_q <= 1'b0;
    end else if (cfg_we_i) begin
      state_q  <= S_CLR;
      pstage_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pstage_q <= pstage_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pstage_d   = pstage_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        if (sts_i.clr_done) state_d = S_IDLE;
        else cmd_o.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready_o = out_free_i;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          pstage_d   = 1'b0;
          state_d    = (op_i == ffha_pkg::OP_ALLOC) ? S_RD : S_FRD;
        end
      end
      S_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_CHK;
      end
      S_CHK: begin
        if (sts_i.walk_end) begin
          cmd_o.res_oom = 1'b1;
          state_d       = S_DONE;
        end else if (sts_i.fits) begin
          cmd_o.split     = sts_i.split_ok;
          cmd_o.mark_used = 1'b1;
          cmd_o.res_ok_a  = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_RD;
        end
      end
      S_FRD: begin
        cmd_o.free_rd = 1'b1;
        state_d       = S_FCHK;
      end
      S_FCHK: begin
        if (!sts_i.free_ok) begin
          cmd_o.res_bad = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.unmark   = 1'b1;
          cmd_o.res_ok_f = 1'b1;
          state_d        = S_MRD;
        end
      end
      S_MRD: begin
        cmd_o.merge_rd = 1'b1;
        state_d        = S_MCHK;
      end
      S_MCHK: begin
        if (sts_i.merge_ok) begin
          cmd_o.merge_wr = 1'b1;
          state_d        = S_FIX;
        end else if (!pstage_q && !sts_i.is_zero) begin
          state_d = S_PRD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FIX: begin
        cmd_o.fix_pred = sts_i.after_ok;
        if (!pstage_q && !sts_i.is_zero) state_d = S_PRD;
        else state_d = S_DONE;
      end
      S_PRD: begin
        cmd_o.pred_rd = 1'b1;
        state_d       = S_PCHK;
      end
      S_PCHK: begin
        pstage_d = 1'b1;
        if (sts_i.pred_ok) begin
          cmd_o.pred_set = 1'b1;
          state_d        = S_MRD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        out_load_o = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_CLR;
    endcase
  end
endmodule

FILE: hdl/first_fit_heap_allocator_unit.sv
// first-fit heap allocator: top level with stream ports and config write port
// alloc walks the chunks from unit zero to the first free chunk that fits; free checks the address, then merges
// throughput: one item at a time, the next item is taken only after the result loads
// result sits in an output register; next item is taken once it is free
// reset and every config write run a clearing pass over the chunk tables
// depends on ffha_pkg, ffha_ctrl and ffha_datapath
module first_fit_heap_allocator_unit #(
  parameter int UNIT_BYTES = 16,
  parameter int HEAP_UNITS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // opcode, request_bytes, block_address, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // status, granted_address, zero pad
);
  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;
  logic out_load, in_fire;
  logic [1:0]  st;
  logic [31:0] ga;
  logic        vld_q;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  ffha_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i,
    .in_fire_i(in_fire), .in_ready_o(s_axis_tready),
    .out_free_i(!vld_q || m_axis_tready), .out_load_o(out_load),
    .op_i(s_axis_tdata[0]), .sts_i(sts), .cmd_o(cmd)
  );

  ffha_datapath #(.UnitBytes(UNIT_BYTES), .HeapUnits(HEAP_UNITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i(s_axis_tdata[16:1]), .addr_i(s_axis_tdata[48:17]),
    .status_o(st), .grant_o(ga)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (out_load) vld_q <= 1'b1;
    else if (m_axis_tready) vld_q <= 1'b0;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {6'd0, ga, st};
endmodule

FILE: dv/first_fit_heap_allocator_unit_tb.sv
// testbench for the first-fit heap allocator: directed and random alloc/free items
// checked against an in-bench heap predictor; depends on ffha_pkg and the top level
module first_fit_heap_allocator_unit_tb;

  localparam int UNITB = 16;
  localparam int UNITS = 4096;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] granted;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // opcode, request_bytes, block_address, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // status, granted_address, zero pad

  first_fit_heap_allocator_unit dut (.*);

  always #2 clk_i = ~clk_i;

  // heap shadow
  logic [31:0] heap_base_q;
  logic [16:0] heap_bytes_q;
  int unsigned heap_units;
  bit          start_f [UNITS];
  bit          used_f  [UNITS];
  int unsigned len_u   [UNITS];
  int unsigned pred_u  [UNITS];

  alloc_result_t result_q[$];
  logic [31:0]   live_q[$];
  int            errors = 0;
  bit            quiet = 0;
  bit            hold_req = 0;
  int            hold_cnt = 0;
  int            rx_stall = 0;

  function automatic void heap_rebuild();
    int unsigned u;
    u = heap_bytes_q / UNITB;
    if (u > UNITS) u = UNITS;
    heap_units = u;
    for (int k = 0; k < UNITS; k++) begin
      start_f[k] = 0; used_f[k] = 0; len_u[k] = 0; pred_u[k] = 0;
    end
    if (u > 0) begin
      start_f[0] = 1;
      len_u[0] = u;
    end
  endfunction

  function automatic void absorb_next(int unsigned a);
    int unsigned n, nn;
    n = a + len_u[a];
    if (n >= heap_units || !start_f[n] || used_f[n]) return;
    len_u[a] += len_u[n];
    start_f[n] = 0;
    len_u[n] = 0;
    nn = a + len_u[a];
    if (nn < heap_units) pred_u[nn] = a;
  endfunction

  function automatic alloc_result_t heap_alloc(logic [15:0] req);
    alloc_result_t r;
    int unsigned need, i, len, steps, n, after;
    r.status = ffha_pkg::ST_OOM;
    r.granted = '0;
    need = (int'(req) + UNITB - 1) / UNITB + 1;
    i = 0;
    steps = 0;
    while (i < heap_units && steps < UNITS) begin
      len = len_u[i];
      if (len == 0) break;
      if (!used_f[i] && len >= need) begin
        if (len - need > 2) begin
          n = i + need;
          after = i + len;
          start_f[n] = 1;
          used_f[n] = 0;
          len_u[n] = len - need;
          pred_u[n] = i;
          if (after < heap_units) pred_u[after] = n;
          len_u[i] = need;
        end
        used_f[i] = 1;
        r.status = ffha_pkg::ST_OK;
        r.granted = heap_base_q + 32'((i + 1) * UNITB);
        return r;
      end
      i += len;
      steps++;
    end
    return r;
  endfunction

  function automatic alloc_result_t heap_free(logic [31:0] a);
    alloc_result_t r;
    logic [31:0] off;
    int unsigned q, i, p;
    r.status = ffha_pkg::ST_BADFREE;
    r.granted = '0;
    off = a - heap_base_q;
    if (off % UNITB != 0) return r;
    q = off / UNITB;
    if (q == 0 || q > heap_units) return r;
    i = q - 1;
    if (!start_f[i] || !used_f[i]) return r;
    used_f[i] = 0;
    absorb_next(i);
    if (i != 0) begin
      p = pred_u[i];
      if (p < heap_units && start_f[p] && !used_f[p]) absorb_next(p);
    end
    r.status = ffha_pkg::ST_OK;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic op, logic [15:0] req, logic [31:0] addr);
    alloc_result_t r;
    int g;
    r = (op == ffha_pkg::OP_ALLOC) ? heap_alloc(req) : heap_free(addr);
    result_q.push_back(r);
    if (op == ffha_pkg::OP_ALLOC && r.status == ffha_pkg::ST_OK) live_q.push_back(r.granted);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, addr, req, op};
    do @(posedge clk_i); while (!s_axis_tready);
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ffha_pkg::CFG_BASE) heap_base_q = val;
    else heap_bytes_q = val[16:0];
    heap_rebuild();
    live_q.delete();
    repeat (2) @(posedge clk_i);
    // clearing pass holds off the input
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          if (m_axis_tdata[1:0] !== result_q[0].status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     result_q[0].status, m_axis_tdata[1:0]);
            errors++;
          end
          if (m_axis_tdata[33:2] !== result_q[0].granted) begin
            $display("%0t: address mismatch, expected %h, actual %h", $time,
                     result_q[0].granted, m_axis_tdata[33:2]);
            errors++;
          end
          void'(result_q.pop_front());
        end
      end
    end
  end

  // receiver stalls, long hold counted here
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_default_heap();
    // default 64 KiB heap at address zero
    send_item(ffha_pkg::OP_ALLOC, 16'd0, 32'd0);
    send_item(ffha_pkg::OP_ALLOC, 16'hFFFF, 32'd0);       // needs more than the heap
    send_item(ffha_pkg::OP_ALLOC, 16'd1, 32'd0);
    send_item(ffha_pkg::OP_ALLOC, 16'd16, 32'd0);
    send_item(ffha_pkg::OP_ALLOC, 16'd17, 32'd0);
    send_item(ffha_pkg::OP_FREE, 16'hFFFF, 32'd32);
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'd32);          // double free
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'd0);           // header of unit zero
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'd40);          // misaligned
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'hFFFF_FFF0);   // beyond the heap
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'd16);
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'd64);          // start of a middle payload
    send_item(ffha_pkg::OP_ALLOC, 16'd65000, 32'd0);
    send_item(ffha_pkg::OP_ALLOC, 16'd1000, 32'd0);
  endtask

  task automatic test_split_edges();
    // remainder of exactly two units stays, three units splits
    write_reg(ffha_pkg::CFG_BASE, 32'h0000_1000);
    write_reg(ffha_pkg::CFG_BYTES, 32'd128);
    send_item(ffha_pkg::OP_ALLOC, 16'd80, 32'd0);         // 6 of 8 units, no split
    send_item(ffha_pkg::OP_ALLOC, 16'd0, 32'd0);
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'h0000_1010);
    send_item(ffha_pkg::OP_ALLOC, 16'd64, 32'd0);         // 5 of 8 units, split
    send_item(ffha_pkg::OP_ALLOC, 16'd32, 32'd0);
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'h0000_0ff0);   // below base
  endtask

  task automatic test_empty_heap();
    write_reg(ffha_pkg::CFG_BYTES, 32'd15);
    send_item(ffha_pkg::OP_ALLOC, 16'd0, 32'd0);
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'h0000_1010);
    write_reg(ffha_pkg::CFG_BYTES, 32'd0);
    write_reg(ffha_pkg::CFG_BASE, 32'hFFFF_FFFF);
    send_item(ffha_pkg::OP_ALLOC, 16'd5, 32'd0);
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'h0000_000F);
  endtask

  task automatic test_wrap_base();
    // payload addresses wrap past the top of the address space
    write_reg(ffha_pkg::CFG_BASE, 32'hFFFF_FFC0);
    write_reg(ffha_pkg::CFG_BYTES, 32'd65535);
    send_item(ffha_pkg::OP_ALLOC, 16'd30, 32'd0);
    send_item(ffha_pkg::OP_ALLOC, 16'd30, 32'd0);
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'h0000_0010);
    send_item(ffha_pkg::OP_FREE, 16'd0, 32'hFFFF_FFD0);
  endtask

  task automatic random_items(int n);
    int r;
    int k;
    logic [31:0] a;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 45 && live_q.size() > 0) begin
        k = $urandom_range(0, live_q.size() - 1);
        a = live_q[k];
        live_q.delete(k);
        send_item(ffha_pkg::OP_FREE, 16'($urandom), a);
      end else if (r < 52) begin
        a = (live_q.size() > 0 && r < 49) ? live_q[0] + 32'($urandom_range(0, 40)) : $urandom;
        send_item(ffha_pkg::OP_FREE, 16'($urandom), a);
      end else if (r < 56) begin
        send_item(ffha_pkg::OP_ALLOC, 16'($urandom), $urandom);
      end else begin
        send_item(ffha_pkg::OP_ALLOC, 16'($urandom_range(0, 200)), $urandom);
      end
    end
  endtask

  task automatic test_random();
    write_reg(ffha_pkg::CFG_BASE, 32'h0001_0000);
    write_reg(ffha_pkg::CFG_BYTES, 32'd1024);
    random_items(200);
    write_reg(ffha_pkg::CFG_BASE, $urandom);
    write_reg(ffha_pkg::CFG_BYTES, 32'($urandom_range(0, 4096)));
    random_items(200);
    write_reg(ffha_pkg::CFG_BASE, 32'hFFFF_FF00);
    write_reg(ffha_pkg::CFG_BYTES, 32'd2048);
    quiet = 1;
    random_items(100);
    quiet = 0;
    write_reg(ffha_pkg::CFG_BASE, 32'd0);
    write_reg(ffha_pkg::CFG_BYTES, 32'd65536);
    random_items(300);
  endtask

  task automatic test_output_stall();
    write_reg(ffha_pkg::CFG_BYTES, 32'd512);
    hold_req = 1;
    quiet = 1;
    random_items(20);
    quiet = 0;
  endtask

  initial begin
    heap_base_q = '0;
    heap_bytes_q = 17'd65536;
    heap_rebuild();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    test_default_heap();
    test_split_edges();
    test_empty_heap();
    test_wrap_base();
    test_random();
    test_output_stall();
    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
